// ----- rtl/pmt_pkg.sv -----
// Shared types, constants and saturation helpers of the point matrix transform.
package pmt_pkg;

  localparam int DIM      = 4;
  localparam int WORD_W   = 32;
  localparam int ROW_W    = $clog2(DIM);
  localparam int WIDE_W   = 64;
  localparam int RUN_LAST = 2 * DIM - 1;
  localparam int CNT_W    = $clog2(RUN_LAST + 1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_POINT = 2'd1,
    OP_SCALE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [3:0]               elem_index;
    logic signed [WORD_W-1:0] elem_value;
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;
    logic signed [WORD_W-1:0] point_z;
    logic signed [WORD_W-1:0] scale_factor;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] out_x;
    logic signed [WORD_W-1:0] out_y;
    logic signed [WORD_W-1:0] out_z;
    logic signed [WORD_W-1:0] out_w;
    logic                     saturated;
  } out_item_t;

  // One step handed along the row of cells.
  typedef struct packed {
    logic                     valid;
    logic [1:0]               op;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic signed [WORD_W-1:0] operand;
  } token_t;

  localparam logic signed [WIDE_W-1:0] WORD_MAX = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] WORD_MIN = -WIDE_W'(64'sd2147483648);

  function automatic logic sat_hit(input logic signed [WIDE_W-1:0] v);
    return (v > WORD_MAX) || (v < WORD_MIN);
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > WORD_MAX) begin
      r = WORD_W'(WORD_MAX);
    end else if (v < WORD_MIN) begin
      r = WORD_W'(WORD_MIN);
    end else begin
      r = WORD_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- rtl/point_matrix_transform.sv -----
// Top level of the 4x4 homogeneous point transform: sequencer, cell row, result register.
//
// The block holds a 4x4 matrix of signed fixed-point words (FRAC_BITS fraction
// bits), all zero after reset, spread over a row of four column cells. Each cell
// owns one matrix column and one 32x32 multiplier. Opcode 0 writes one element,
// opcode 2 scales every element by a scalar (each product floored and clipped to
// 32 bits), opcode 1 transforms the point (x, y, z, 1) as a row vector times the
// matrix and returns one result with the four clipped sums and a saturation flag;
// opcode 3 does nothing. Every item, whatever its opcode, runs the same sequence
// after its transfer: four row steps (one for a write) enter the first cell one per
// cycle, ripple through three more cells and one product register, then the finish
// cycle clips the sums into the result register; the input stalls until the item
// is through and the block is idle. A finished result waits in its own register,
// so the next item can be taken while it is still stalled; only a transform that
// finishes while the previous result is still waiting holds in its finish cycle.
module point_matrix_transform import pmt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int ACC_W = 2 * WORD_W - FRAC_BITS + ROW_W;
  localparam logic signed [WORD_W-1:0] ONE_W = WORD_W'(64'sd1 << FRAC_BITS);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  in_item_t           item_q;
  logic               in_xfer;
  logic               load_out;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q;
  out_item_t          res;
  token_t             head_tok;

  token_t                  tok [DIM+1];
  logic signed [ACC_W-1:0] acc [DIM];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Next state: run the chain, then finish once the result slot can take it.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RUN_LAST)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!(item_q.opcode == OP_POINT && out_valid_q && out_stall_i)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: feed row steps into the first cell, and load the result register.
  always_comb begin
    head_tok     = '0;
    head_tok.op  = item_q.opcode;
    head_tok.row = cnt_q[ROW_W-1:0];
    load_out     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_RUN: begin
        if (cnt_q < CNT_W'(DIM)) begin
          unique case (item_q.opcode)
            OP_WRITE: begin
              head_tok.valid   = (cnt_q == '0);
              head_tok.row     = item_q.elem_index[3:2];
              head_tok.col     = item_q.elem_index[1:0];
              head_tok.operand = item_q.elem_value;
            end
            OP_SCALE: begin
              head_tok.valid   = 1'b1;
              head_tok.operand = item_q.scale_factor;
            end
            OP_POINT: begin
              head_tok.valid = 1'b1;
              unique case (cnt_q[ROW_W-1:0])
                2'd0:    head_tok.operand = item_q.point_x;
                2'd1:    head_tok.operand = item_q.point_y;
                2'd2:    head_tok.operand = item_q.point_z;
                default: head_tok.operand = ONE_W;
              endcase
            end
            default: begin
            end
          endcase
        end
      end
      ST_FINISH: begin
        load_out = (item_q.opcode == OP_POINT) && !(out_valid_q && out_stall_i);
      end
      default: begin
      end
    endcase
  end

  assign tok[0] = head_tok;

  // Row of column cells; each hands its step on to the next every cycle.
  for (genvar c = 0; c < DIM; c++) begin : g_cell
    pmt_cell #(
      .FRAC_BITS (FRAC_BITS),
      .COL       (c)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[c]),
      .tok_o  (tok[c+1]),
      .acc_o  (acc[c])
    );
  end

  // Clip the four column sums and gather the flag.
  always_comb begin
    res.out_x     = sat_word(WIDE_W'(acc[0]));
    res.out_y     = sat_word(WIDE_W'(acc[1]));
    res.out_z     = sat_word(WIDE_W'(acc[2]));
    res.out_w     = sat_word(WIDE_W'(acc[3]));
    res.saturated = sat_hit(WIDE_W'(acc[0])) || sat_hit(WIDE_W'(acc[1])) ||
                    sat_hit(WIDE_W'(acc[2])) || sat_hit(WIDE_W'(acc[3]));
  end

  // Hold the result until its transfer; a fresh load takes priority over a drain.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_item_i;
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A result appears only out of the finish cycle of a transform.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH) && $past(item_q.opcode == OP_POINT))
    else $error("result raised outside a transform finish");

  // A transform must not leave its finish cycle while the previous result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && item_q.opcode == OP_POINT && out_valid_q && out_stall_i
    |=> state_q == ST_FINISH)
    else $error("transform result dropped while output stalled");

  // No row step enters the chain outside the run phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_tok.valid |-> state_q == ST_RUN && cnt_q < CNT_W'(DIM))
    else $error("row step issued outside the run phase");

endmodule

// ----- rtl/pmt_cell.sv -----
// One column cell: holds a matrix column, multiplies, accumulates and forwards steps.
module pmt_cell import pmt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int COL       = 0
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  token_t                                      tok_i,
  output token_t                                      tok_o,
  output logic signed [2*WORD_W-FRAC_BITS+ROW_W-1:0]  acc_o
);

  localparam int PROD_W = 2 * WORD_W;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int ACC_W  = SH_W + ROW_W;

  token_t                   tok_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [WORD_W-1:0] elem_q [DIM];
  logic signed [WORD_W-1:0] elem_d [DIM];
  logic signed [SH_W-1:0]   shifted;

  // Arithmetic right shift is the floor of the division.
  assign shifted = SH_W'(prod_q >>> FRAC_BITS);

  always_comb begin
    acc_d  = acc_q;
    elem_d = elem_q;
    if (tok_q.valid) begin
      unique case (tok_q.op)
        OP_POINT: begin
          if (tok_q.row == '0) begin
            acc_d = ACC_W'(shifted);
          end else begin
            acc_d = acc_q + ACC_W'(shifted);
          end
        end
        OP_SCALE: begin
          elem_d[tok_q.row] = sat_word(WIDE_W'(shifted));
        end
        OP_WRITE: begin
          if (tok_q.col == ROW_W'(COL)) begin
            elem_d[tok_q.row] = tok_q.operand;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      for (int i = 0; i < DIM; i++) begin
        elem_q[i] <= '0;
      end
    end else begin
      tok_q  <= tok_i;
      elem_q <= elem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= tok_i.operand * elem_q[tok_i.row];
    acc_q  <= acc_d;
  end

  assign tok_o = tok_q;
  assign acc_o = acc_q;

  // A scale write-back never lands on the row being read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.valid && tok_q.valid && tok_q.op == OP_SCALE |-> tok_i.row != tok_q.row)
    else $error("scale write-back collides with element read");

endmodule

// ----- sim/tb_point_matrix_transform.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the 4x4 point matrix transform, with a built-in predictor.
module tb_point_matrix_transform;
  import pmt_pkg::*;

  localparam int FRAC          = 16;
  localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode: no effect, no result
  localparam int CLK_HALF_NS   = 2;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 12;       // busy time of one item, plus margin
  localparam int DRAIN_LIMIT   = 4000;
  localparam int PRESSURE_HOLD = 160;
  localparam int PRESSURE_ITEMS = 14;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int MAX_PRINTS    = 30;
  localparam int RUN_LIMIT_NS  = 2_000_000;

  localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
  localparam logic signed [31:0] W_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] W_MIN  = 32'sh8000_0000;
  localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Predictor state: a private copy of the matrix, and the transform results still owed.
  logic signed [31:0] model_matrix [16];
  out_item_t          expected_points [$];
  out_item_t          oldest_point;

  int  mismatch_count;
  int  items_sent;
  int  points_checked;
  int  saturated_seen;
  int  scales_sent;
  int  hold_request;
  bit  sender_gaps_on;
  bit  receiver_gaps_on;

  point_matrix_transform #(
    .FRAC_BITS (FRAC)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Hard stop, in case a handshake never completes.
  initial begin
    #RUN_LIMIT_NS;
    $display("point_matrix_transform regression: fail");
    $finish;
  end

  task automatic note_mismatch(input string what);
    if (mismatch_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // Clip a wide sum to the signed word range, raising the hit flag on a clip.
  function automatic logic signed [31:0] clip_word(input logic signed [63:0] v,
                                                   inout logic hit);
    if (v > WIDE_MAX) begin
      hit = 1'b1;
      return W_MAX;
    end
    if (v < WIDE_MIN) begin
      hit = 1'b1;
      return W_MIN;
    end
    return v[31:0];
  endfunction

  // Apply one item to the private matrix; return 1 with the expected point when it
  // is a transform. Products are floored by an arithmetic shift of the full product.
  function automatic logic predict_point(input in_item_t it, output out_item_t res);
    logic signed [63:0] coord [4];
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] acc;
    logic signed [31:0] sum_word [4];
    logic               clipped;
    clipped = 1'b0;
    res     = '0;
    case (it.opcode)
      OP_WRITE: begin
        model_matrix[it.elem_index] = it.elem_value;
        return 1'b0;
      end
      OP_SCALE: begin
        b = $signed(it.scale_factor);
        for (int i = 0; i < 16; i++) begin
          a = model_matrix[i];
          // Element clips are silent: the flag is thrown away.
          model_matrix[i] = clip_word((a * b) >>> FRAC, clipped);
        end
        return 1'b0;
      end
      OP_POINT: begin
        coord[0] = $signed(it.point_x);
        coord[1] = $signed(it.point_y);
        coord[2] = $signed(it.point_z);
        coord[3] = 64'sd1 <<< FRAC;   // homogeneous w is exactly one
        for (int c = 0; c < 4; c++) begin
          acc = '0;
          for (int r = 0; r < 4; r++) begin
            a   = model_matrix[r * 4 + c];
            acc = acc + ((coord[r] * a) >>> FRAC);
          end
          sum_word[c] = clip_word(acc, clipped);
        end
        res.out_x     = sum_word[0];
        res.out_y     = sum_word[1];
        res.out_z     = sum_word[2];
        res.out_w     = sum_word[3];
        res.saturated = clipped;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Every field random; the caller overrides what the opcode actually uses.
  function automatic in_item_t noise_item();
    in_item_t n;
    n.opcode       = 2'($urandom);
    n.elem_index   = 4'($urandom);
    n.elem_value   = $urandom;
    n.point_x      = $urandom;
    n.point_y      = $urandom;
    n.point_z      = $urandom;
    n.scale_factor = $urandom;
    return n;
  endfunction

  // Extremes, unity values, full-range noise and small coordinates within +/-8.0.
  function automatic logic signed [31:0] rand_word();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = W_MAX;
      1: v = W_MIN;
      2: v = '0;
      3: v = Q_ONE;
      4: v = -Q_ONE;
      5, 6: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0010_0000);
        v = v - 32'sh0008_0000;
      end
    endcase
    return v;
  endfunction

  // Send one item: idle for a drawn gap, then hold it until the transfer. The stall
  // is sampled at the falling edge, where it is settled for the coming rising edge.
  task automatic push_item(input in_item_t it);
    int        gap;
    logic      taken;
    out_item_t res;
    gap = sender_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_item  <= noise_item();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      if (taken && predict_point(it, res)) begin
        expected_points.push_back(res);
      end
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic write_elem(input logic [3:0] idx, input logic signed [31:0] val);
    in_item_t it;
    it            = noise_item();
    it.opcode     = OP_WRITE;
    it.elem_index = idx;
    it.elem_value = val;
    push_item(it);
  endtask

  task automatic xform(input logic signed [31:0] x, input logic signed [31:0] y,
                       input logic signed [31:0] z);
    in_item_t it;
    it         = noise_item();
    it.opcode  = OP_POINT;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    push_item(it);
  endtask

  task automatic scale_by(input logic signed [31:0] s);
    in_item_t it;
    it              = noise_item();
    it.opcode       = OP_SCALE;
    it.scale_factor = s;
    push_item(it);
    scales_sent++;
  endtask

  task automatic send_nop();
    in_item_t it;
    it        = noise_item();
    it.opcode = OP_NONE;
    push_item(it);
  endtask

  // Drop valid, wait for every owed result, then let the last item leave the pipe.
  task automatic settle();
    in_valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && expected_points.size() != 0; k++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result sink: draw a stall length per result, or take a long hold when asked.
  initial begin : result_sink
    int   hold;
    logic got;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        hold         = hold_request;
        hold_request = 0;
      end else begin
        hold = receiver_gaps_on ? $urandom_range(0, 4) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got = out_valid;
        @(posedge clk);
      end while (!got);
    end
  end

  // Result checker: compare each transfer with the oldest owed point.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        note_mismatch($sformatf("result with nothing owed: %h", out_item));
      end else begin
        oldest_point = expected_points.pop_front();
        points_checked++;
        if (out_item.saturated) begin
          saturated_seen++;
        end
        if (out_item.out_x !== oldest_point.out_x) begin
          note_mismatch($sformatf("out_x %h, want %h", out_item.out_x, oldest_point.out_x));
        end
        if (out_item.out_y !== oldest_point.out_y) begin
          note_mismatch($sformatf("out_y %h, want %h", out_item.out_y, oldest_point.out_y));
        end
        if (out_item.out_z !== oldest_point.out_z) begin
          note_mismatch($sformatf("out_z %h, want %h", out_item.out_z, oldest_point.out_z));
        end
        if (out_item.out_w !== oldest_point.out_w) begin
          note_mismatch($sformatf("out_w %h, want %h", out_item.out_w, oldest_point.out_w));
        end
        if (out_item.saturated !== oldest_point.saturated) begin
          note_mismatch($sformatf("saturated %b, want %b",
                                  out_item.saturated, oldest_point.saturated));
        end
      end
    end
  end

  // The matrix is all zero after reset; an unused opcode must leave it so.
  task automatic test_reset_state();
    xform(Q_ONE, 2 * Q_ONE, 3 * Q_ONE);
    send_nop();
    xform(W_MAX, W_MIN, -Q_ONE);
    settle();
  endtask

  // Identity plus a translation row, then a floor of a tiny negative product.
  task automatic test_element_writes();
    for (int i = 0; i < 4; i++) begin
      write_elem(4'(i * 5), Q_ONE);
    end
    write_elem(4'd12, 32'sh0005_0000);
    write_elem(4'd13, -32'sh0007_8000);
    write_elem(4'd14, 32'sh0000_4000);
    xform(Q_ONE, -2 * Q_ONE, 32'sh0001_8000);
    write_elem(4'd1, -32'sd1);
    xform(32'sd1, '0, '0);
    settle();
  endtask

  // Drive column sums past both ends of the word range.
  task automatic test_saturation();
    write_elem(4'd0, W_MAX);
    write_elem(4'd4, W_MAX);
    write_elem(4'd8, W_MAX);
    xform(W_MAX, W_MAX, W_MAX);
    xform(W_MIN, W_MIN, W_MIN);
    write_elem(4'd15, W_MIN);
    write_elem(4'd0, W_MIN);
    xform(W_MIN, '0, '0);
    settle();
  endtask

  // Scale by a half, by both extremes (elements clip silently), by a tiny negative
  // value (floor towards minus infinity) and finally by zero.
  task automatic test_matrix_scale();
    scale_by(Q_HALF);
    xform(Q_ONE, Q_ONE, Q_ONE);
    scale_by(W_MAX);
    xform(Q_ONE, -Q_ONE, Q_HALF);
    scale_by(W_MIN);
    xform(Q_ONE, Q_ONE, -Q_ONE);
    scale_by(-32'sd1);
    xform(W_MAX, '0, W_MIN);
    scale_by('0);
    xform(W_MAX, W_MAX, W_MAX);
    settle();
  endtask

  // Hold the result side for a long stretch while points keep coming, so that the
  // result register fills and the block stalls its input.
  task automatic test_back_pressure();
    write_elem(4'd0, Q_ONE);
    write_elem(4'd5, Q_ONE);
    write_elem(4'd10, Q_ONE);
    write_elem(4'd15, Q_ONE);
    sender_gaps_on = 1'b0;
    hold_request   = PRESSURE_HOLD;
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      xform(rand_word(), rand_word(), rand_word());
    end
    settle();
    sender_gaps_on = 1'b1;
  endtask

  // Mostly writes and points, some scales near unity, a few unused opcodes; idling
  // is switched per stretch so that calm and busy runs both occur.
  task automatic test_random_stream();
    int                 pick;
    logic signed [31:0] s;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 128 == 0) begin
        sender_gaps_on   = ($urandom_range(0, 3) != 0);
        receiver_gaps_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        write_elem(4'($urandom), rand_word());
      end else if (pick < 88) begin
        xform(rand_word(), rand_word(), rand_word());
      end else if (pick < 94) begin
        if ($urandom_range(0, 7) == 0) begin
          s = rand_word();
        end else begin
          s = $urandom_range(0, 32'h0001_0000);
          s = s + Q_HALF;
        end
        scale_by(s);
      end else begin
        send_nop();
      end
    end
    settle();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_item          <= '0;
    mismatch_count   = 0;
    items_sent       = 0;
    points_checked   = 0;
    saturated_seen   = 0;
    scales_sent      = 0;
    hold_request     = 0;
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
    for (int i = 0; i < 16; i++) begin
      model_matrix[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_element_writes();
    test_saturation();
    test_matrix_scale();
    test_back_pressure();
    test_random_stream();

    if (expected_points.size() != 0) begin
      note_mismatch($sformatf("%0d transform results never arrived", expected_points.size()));
    end
    $display("covered %0d items: %0d transformed points checked, %0d of them clipped,",
             items_sent, points_checked, saturated_seen);
    $display("%0d matrix scales, unused opcodes and a long result-side hold", scales_sent);
    if (mismatch_count == 0) begin
      $display("point_matrix_transform regression: pass");
    end else begin
      $display("point_matrix_transform regression: fail");
    end
    $finish;
  end

endmodule
